/* rtl/ntp_pkg.sv */
// Shared types, constants and the step scale table for the note-to-pitch converter.
`default_nettype none

package ntp_pkg;

    localparam int POS_W        = 14;      // note * 128 + fine
    localparam int OCT_QBITS    = 4;       // octave count, at most ten and one more on wrap
    localparam int OCTAVE_UNITS = 1536;
    localparam int REM_W        = 11;      // remainder inside one octave
    localparam int FRAC_W       = 5;
    localparam int STEP_W       = REM_W - FRAC_W;
    localparam int BASE_W       = 16;
    localparam int SCALE_W      = 14;
    localparam int SCALE_FRAC   = 12;
    localparam int SCALE_ENTRIES = 49;     // S(0) .. S(48)
    localparam int SCALE_DEPTH  = 1 << STEP_W;
    localparam int PROD_W       = BASE_W + SCALE_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int PITCH_W      = 14;

    localparam logic [BASE_W-1:0]  UNITY_BASE = 16'h1000;
    localparam int                 STEP_RATIO = 32'h103B;
    localparam logic [PITCH_W-1:0] PITCH_MAX  = 14'h3FFF;

    typedef logic [SCALE_DEPTH-1:0][SCALE_W-1:0] scale_tab_t;

    // Item moving down the divider chain.
    typedef struct packed {
        logic                 vld;
        logic                 neg;
        logic [POS_W-1:0]     rem;
        logic [OCT_QBITS-1:0] octs;
    } ntp_div_t;

    // Finished conversion handed to the output register.
    typedef struct packed {
        logic               vld;
        logic [PITCH_W-1:0] pitch;
    } ntp_res_t;

    // S(k+1) = S(k) * 0x103B / 4096, truncated; unused tail entries are zero.
    function automatic scale_tab_t build_scale_tab();
        scale_tab_t  t;
        logic [31:0] s;
        t = '0;
        s = 32'd4096;
        for (int k = 0; k < SCALE_ENTRIES; k++)
        begin
            t[k] = SCALE_W'(s);
            s    = (s * 32'(STEP_RATIO)) >> SCALE_FRAC;
        end
        return t;
    endfunction

    localparam scale_tab_t SCALE_TAB = build_scale_tab();

endpackage

`default_nettype wire

/* rtl/ntp_div_cell.sv */
// One restoring-division cell: extracts one octave quotient bit per stage.
`default_nettype none

module ntp_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  ntp_pkg::ntp_div_t din,
    output ntp_pkg::ntp_div_t dout
);
    import ntp_pkg::*;

    localparam logic [POS_W:0] DIVISOR = (POS_W+1)'(OCTAVE_UNITS << SHIFT);

    logic           ge;
    logic [POS_W:0] diff;
    ntp_div_t       cell_next;
    ntp_div_t       cell_reg;

    always_comb
    begin
        diff      = {1'b0, din.rem} - DIVISOR;
        ge        = ({1'b0, din.rem} >= DIVISOR);
        cell_next = din;
        cell_next.rem  = ge ? diff[POS_W-1:0] : din.rem;
        cell_next.octs = {din.octs[OCT_QBITS-2:0], ge};
    end

    // Hold while the output side stalls, advance otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (adv)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

/* rtl/ntp_interp.sv */
// Octave fold, scale lookup, linear interpolation between scale steps and saturation.
`default_nettype none

module ntp_interp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  ntp_pkg::ntp_div_t din,
    output ntp_pkg::ntp_res_t res
);
    import ntp_pkg::*;

    // lookup stage
    logic                 wrap;
    logic [REM_W-1:0]     rem_in;
    logic [REM_W-1:0]     rem_adj;
    logic [OCT_QBITS-1:0] octs_adj;
    logic [STEP_W-1:0]    steps;
    logic [BASE_W-1:0]    base_next;
    logic [SCALE_W-1:0]   s_lo_next;
    logic [SCALE_W-1:0]   s_hi_next;
    logic [FRAC_W-1:0]    frac_next;

    logic                 a_vld_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [SCALE_W-1:0]   s_lo_reg;
    logic [SCALE_W-1:0]   s_hi_reg;
    logic [FRAC_W-1:0]    frac_a_reg;

    // multiply stage
    logic [PROD_W-1:0]    lo_next;
    logic [PROD_W-1:0]    hi_next;
    logic                 b_vld_reg;
    logic [PROD_W-1:0]    lo_b_reg;
    logic [PROD_W-1:0]    hi_b_reg;
    logic [FRAC_W-1:0]    frac_b_reg;

    // interpolation stage
    logic [PROD_W-1:0]    slope;
    logic [PROD_W-1:0]    prod_next;
    logic                 c_vld_reg;
    logic [PROD_W-1:0]    lo_c_reg;
    logic [PROD_W-1:0]    prod_reg;

    // final sum and saturation
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     scaled;

    always_comb
    begin
        rem_in   = din.rem[REM_W-1:0];
        wrap     = din.neg && (rem_in != '0);
        octs_adj = wrap ? din.octs + OCT_QBITS'(1) : din.octs;
        rem_adj  = wrap ? REM_W'(OCTAVE_UNITS) - rem_in : rem_in;
        if (din.neg)
        begin
            base_next = UNITY_BASE >> octs_adj;
        end
        else
        begin
            base_next = BASE_W'(32'(UNITY_BASE) << octs_adj);
        end
        steps     = rem_adj[REM_W-1:FRAC_W];
        frac_next = rem_adj[FRAC_W-1:0];
        s_lo_next = SCALE_TAB[steps];
        s_hi_next = SCALE_TAB[steps + STEP_W'(1)];
    end

    assign lo_next   = PROD_W'(base_reg) * PROD_W'(s_lo_reg);
    assign hi_next   = PROD_W'(base_reg) * PROD_W'(s_hi_reg);
    assign slope     = (hi_b_reg - lo_b_reg) >> FRAC_W;
    assign prod_next = slope * PROD_W'(frac_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= din.vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            base_reg   <= base_next;
            s_lo_reg   <= s_lo_next;
            s_hi_reg   <= s_hi_next;
            frac_a_reg <= frac_next;
            lo_b_reg   <= lo_next;
            hi_b_reg   <= hi_next;
            frac_b_reg <= frac_a_reg;
            lo_c_reg   <= lo_b_reg;
            prod_reg   <= prod_next;
        end
    end

    always_comb
    begin
        sum    = SUM_W'(lo_c_reg) + SUM_W'(prod_reg);
        scaled = sum >> SCALE_FRAC;
        res.vld = c_vld_reg;
        if (scaled > SUM_W'(PITCH_MAX))
        begin
            res.pitch = PITCH_MAX;
        end
        else
        begin
            res.pitch = scaled[PITCH_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/note_to_pitch_converter.sv */
// Top level of the note-to-pitch converter: divider chain, interpolator, output register.
// Pipeline: 4 divider cells, 3 interpolation stages, 1 output register.
// Throughput: one conversion per cycle; the whole pipeline advances together and
//   holds as one while a finished result waits on out_ready.
// Reset: rst_n clears stage and output valid bits and divider cell data; no other state.
`default_nettype none

module note_to_pitch_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [6:0] center_note,
    input  logic [6:0] center_fine,
    input  logic [6:0] target_note,
    input  logic [6:0] target_fine,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [13:0] pitch_word
);
    import ntp_pkg::*;

    logic             adv;
    logic [POS_W-1:0] cpos;
    logic [POS_W-1:0] tpos;
    logic             neg;
    logic [POS_W-1:0] mag;
    ntp_div_t         chain [OCT_QBITS+1];
    ntp_res_t         res;

    logic               out_valid_reg;
    logic [PITCH_W-1:0] pitch_reg;

    // Advance every stage unless a finished result is stuck at the output.
    // A new item enters on the same advance, so ready follows the output side only.
    assign adv      = !(out_valid_reg && !out_ready);
    assign in_ready = adv;

    // Positions in 1/128 semitone units, and the distance between them.
    // A downward offset travels as a magnitude with a sign flag; the
    // interpolator folds it back into the lower octave.
    assign cpos = {center_note, center_fine};
    assign tpos = {target_note, target_fine};
    assign neg  = (tpos < cpos);
    assign mag  = neg ? (cpos - tpos) : (tpos - cpos);

    always_comb
    begin
        chain[0].vld  = in_valid;
        chain[0].neg  = neg;
        chain[0].rem  = mag;
        chain[0].octs = '0;
    end

    // Divide the magnitude by one octave, one quotient bit per cell, MSB first.
    // Each cell compares against 1536 shifted to its bit position and hands
    // the partial remainder and quotient to the next cell.
    for (genvar i = 0; i < OCT_QBITS; i++)
    begin : g_div
        ntp_div_cell #(
            .SHIFT(OCT_QBITS - 1 - i)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .adv  (adv),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    // Base shift, scale table lookup, two products, slope times fraction, saturation.
    ntp_interp u_interp (
        .clk  (clk),
        .rst_n(rst_n),
        .adv  (adv),
        .din  (chain[OCT_QBITS]),
        .res  (res)
    );

    // Output register: parts the pipeline from the consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_reg <= res.pitch;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pitch_word = pitch_reg;

endmodule

`default_nettype wire

/* rtl/ntp_checker.sv */
// Port-level checks for the note-to-pitch converter, bound to the top level.
`default_nettype none

module ntp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [6:0]  center_note,
    input logic [6:0]  center_fine,
    input logic [6:0]  target_note,
    input logic [6:0]  target_fine,
    input logic        out_valid,
    input logic        out_ready,
    input logic [13:0] pitch_word
);

    // A stalled input transfer keeps its valid and payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(center_note) && $stable(center_fine)
            && $stable(target_note) && $stable(target_fine))
        else $error("input payload changed while stalled");

    // A stalled result keeps its valid and value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pitch_word))
        else $error("result changed while stalled");

    // With no result waiting the block must take input.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // A new result appears only right after an advance of the pipeline.
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared while pipeline was held");

endmodule

bind note_to_pitch_converter ntp_checker u_ntp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .center_note(center_note),
    .center_fine(center_fine),
    .target_note(target_note),
    .target_fine(target_fine),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pitch_word (pitch_word)
);

`default_nettype wire

/* dv/tb_note_to_pitch_converter.sv */
// Self-checking testbench for the note-to-pitch converter.
`timescale 1ns / 100ps

module tb_note_to_pitch_converter;

    // Pitch arithmetic constants: the octave span in fine units, the unity
    // base, the per-step ratio in 4.12 fixed point, the saturation limit.
    localparam int unsigned OCT_SPAN    = 1536;
    localparam int unsigned UNITY       = 32'h1000;
    localparam int unsigned RATIO       = 32'h103B;
    localparam int unsigned BASE_KEEP   = 32'hFFFF;
    localparam int unsigned FRAC_KEEP   = 32'h1F;
    localparam int unsigned PITCH_CLAMP = 32'h3FFF;
    localparam int unsigned POS_MAX     = 16383;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 24;      // settle time, well past the pipeline
    localparam int HOLD_TICKS   = 300;

    // One conversion in flight: the operands for reporting, the predicted word.
    typedef struct {
        logic [6:0]  cn;
        logic [6:0]  cf;
        logic [6:0]  tn;
        logic [6:0]  tf;
        logic [13:0] pitch;
    } pitch_req_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [6:0]  center_note;
    logic [6:0]  center_fine;
    logic [6:0]  target_note;
    logic [6:0]  target_fine;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [13:0] pitch_word;

    pitch_req_t  pitch_expected_q[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_req;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          cycle_cnt = 0;
    int          err_cnt = 0;
    int          checked_cnt = 0;
    int          random_cnt;

    note_to_pitch_converter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .center_note (center_note),
        .center_fine (center_fine),
        .target_note (target_note),
        .target_fine (target_fine),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pitch_word  (pitch_word)
    );

    // 20 ns clock.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predict the pitch word for one pair of positions. Each position is
    // note * 128 + fine. Upward offsets shift the unity base left by whole
    // octaves and keep 16 bits; downward offsets round to the lower octave
    // and count the remainder upward from there. The remainder then walks
    // the truncated step scale and the low 5 bits interpolate.
    function automatic logic [13:0] predict_pitch(input logic [6:0] cn, input logic [6:0] cf,
                                                  input logic [6:0] tn, input logic [6:0] tf);
        int unsigned cpos, tpos, delta, octs, rem, base;
        int unsigned steps, frac, s_lo, s_hi, lo, hi, acc;
        cpos = {cn, cf};
        tpos = {tn, tf};
        if (tpos >= cpos)
        begin
            delta = tpos - cpos;
            octs  = delta / OCT_SPAN;
            rem   = delta % OCT_SPAN;
            base  = (octs < 16) ? ((UNITY << octs) & BASE_KEEP) : 0;
        end
        else
        begin
            delta = cpos - tpos;
            octs  = delta / OCT_SPAN;
            rem   = delta % OCT_SPAN;
            // round toward the lower octave, then count back up
            if (rem != 0)
            begin
                octs = octs + 1;
                rem  = OCT_SPAN - rem;
            end
            base = (octs < 16) ? ((UNITY >> octs) & BASE_KEEP) : 0;
        end
        steps = rem >> 5;
        frac  = rem & FRAC_KEEP;
        s_lo  = UNITY;
        s_hi  = RATIO;
        for (int unsigned k = 0; k < steps; k++)
        begin
            s_lo = s_hi;
            s_hi = (s_hi * RATIO) >> 12;
        end
        lo  = base * s_lo;
        hi  = base * s_hi;
        acc = (lo + ((hi - lo) >> 5) * frac) >> 12;
        if (acc > PITCH_CLAMP)
            acc = PITCH_CLAMP;
        return acc[13:0];
    endfunction

    // Offer one conversion and wait for its transfer. Idle the input first
    // at the current sender rate; valid stays high from the previous item
    // when no idle cycle is drawn. Record the prediction on transfer.
    task automatic send_item(input logic [6:0] cn, input logic [6:0] cf,
                             input logic [6:0] tn, input logic [6:0] tf);
        pitch_req_t req;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        center_note <= cn;
        center_fine <= cf;
        target_note <= tn;
        target_fine <= tf;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        req.cn    = cn;
        req.cf    = cf;
        req.tn    = tn;
        req.tf    = tf;
        req.pitch = predict_pitch(cn, cf, tn, tf);
        pitch_expected_q.push_back(req);
    endtask

    // Drop valid and wait for every outstanding conversion, then let the
    // pipeline settle.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pitch_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Equal positions, fine-only and in-octave offsets and the first interpolation steps.
    task automatic test_unity_and_fine();
        send_item(7'd60, 7'd0, 7'd60, 7'd0);       // unity
        send_item(7'd0, 7'd0, 7'd0, 7'd0);         // unity at the bottom
        send_item(7'd127, 7'd127, 7'd127, 7'd127); // unity at the top
        send_item(7'd60, 7'd0, 7'd60, 7'd1);       // one fine unit up
        send_item(7'd60, 7'd0, 7'd60, 7'd31);      // largest fraction in step 0
        send_item(7'd60, 7'd0, 7'd60, 7'd32);      // first full step
        send_item(7'd0, 7'd127, 7'd0, 7'd0);       // fine-only downward offset
        send_item(7'd60, 7'd64, 7'd66, 7'd0);      // mid-octave with fine
        send_item(7'd60, 7'd0, 7'd71, 7'd127);     // last unit of the octave
        send_item(7'd42, 7'd85, 7'd42, 7'd42);     // alternating fine bits
    endtask

    // Whole-octave edges, saturation, base overflow and deep downward shifts.
    task automatic test_octave_edges();
        send_item(7'd60, 7'd0, 7'd72, 7'd0);       // one octave up
        send_item(7'd60, 7'd0, 7'd84, 7'd0);       // two octaves up, saturates
        send_item(7'd60, 7'd0, 7'd96, 7'd0);       // three octaves up, saturates
        send_item(7'd60, 7'd0, 7'd108, 7'd0);      // four octaves: base shifts out
        send_item(7'd0, 7'd0, 7'd127, 7'd127);     // largest upward offset
        send_item(7'd60, 7'd0, 7'd48, 7'd0);       // exactly one octave down
        send_item(7'd60, 7'd0, 7'd59, 7'd127);     // one unit down, lower octave
        send_item(7'd120, 7'd0, 7'd0, 7'd0);       // ten octaves down
        send_item(7'd127, 7'd0, 7'd0, 7'd0);       // rounds to eleven octaves
        send_item(7'd127, 7'd127, 7'd0, 7'd0);     // largest downward offset
        send_item(7'd0, 7'd0, 7'd23, 7'd127);      // just under two octaves up
        send_item(7'd85, 7'd42, 7'd85, 7'd85);
    endtask

    // Hold the output off for a long stretch while offering items back to
    // back, so the pipeline fills and input ready drops.
    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req     <= 1'b1;
        repeat (40)
            send_item(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        hold_req     <= 1'b0;
        wait_drain();
    endtask

    // Random conversions. Most keep the target within four octaves and 64 fine
    // units of the center, where the base mostly survives and the scale walk
    // matters; the rest draw every field at random.
    task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
        int          mode;
        int          cpos;
        int          tpos;
        int          offs;
        logic [13:0] tword;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            cpos = $urandom_range(0, POS_MAX);
            if (mode < 3)
                tpos = $urandom_range(0, POS_MAX);
            else
            begin
                offs = (mode == 9) ? $urandom_range(0, 64) : $urandom_range(0, 4 * OCT_SPAN + 64);
                tpos = $urandom_range(0, 1) ? cpos + offs : cpos - offs;
                if (tpos < 0 || tpos > POS_MAX)
                    tpos = $urandom_range(0, POS_MAX);
            end
            tword = 14'(tpos);
            send_item(7'(cpos >> 7), 7'(cpos), tword[13:7], tword[6:0]);
            random_cnt++;
        end
        wait_drain();
    endtask

    // Receiver: stall at the current rate; when a hold request rises, count
    // a long stretch of back-pressure here.
    always @(posedge clk)
    begin
        hold_seen <= hold_req;
        if (hold_req && !hold_seen)
        begin
            hold_left <= HOLD_TICKS;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each output transfer with the oldest pending prediction.
    always @(posedge clk)
    begin : check_pitch
        pitch_req_t exp_item;
        if (rst_n && out_valid && out_ready)
        begin
            if (pitch_expected_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: pitch_word %h with nothing pending", $time, pitch_word);
            end
            else
            begin
                exp_item = pitch_expected_q.pop_front();
                checked_cnt++;
                if (pitch_word !== exp_item.pitch)
                begin
                    err_cnt++;
                    $display("%0t: center %0d/%0d target %0d/%0d expected %h actual %h",
                             $time, exp_item.cn, exp_item.cf, exp_item.tn, exp_item.tf,
                             exp_item.pitch, pitch_word);
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d conversions pending", $time, pitch_expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        center_note   = '0;
        center_fine   = '0;
        target_note   = '0;
        target_fine   = '0;
        hold_req      = 1'b0;
        random_cnt    = 0;
        send_idle_pct = 18;
        recv_idle_pct = 69;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unity_and_fine();
        test_octave_edges();
        wait_drain();
        test_backpressure_fill();
        test_random(700, 18, 69);
        test_random(700, 69, 18);
        test_random(600, 0, 0);

        $display("tb: %0d conversions checked: fine and octave edges, saturation, base overflow,",
                 checked_cnt);
        $display("tb: a long output hold and %0d random items under three stall mixes",
                 random_cnt);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/ntp_pkg.sv
rtl/ntp_div_cell.sv
rtl/ntp_interp.sv
rtl/note_to_pitch_converter.sv
rtl/ntp_checker.sv
dv/tb_note_to_pitch_converter.sv
